// ===== rtl/core/dsot_pkg.sv =====
// Shared types and constants for the distance-sorted offset table.
// No dependencies; used by dsot_ctrl, dsot_datapath and the top level.
package dsot_pkg;

   localparam int TABLE_DEPTH     = 256;
   localparam int MAX_HALF_EXTENT = 7;
   localparam int ADDR_W          = 8;   // table address bits
   localparam int CNT_W           = 9;   // counts up to TABLE_DEPTH
   localparam int COORD_W         = 4;
   localparam int DIST_W          = 7;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DY     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_ZERO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_LIMIT = 3'd3;

   // request actions
   localparam logic ACT_BUILD = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [DIST_W-1:0]         d;
   } entry_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_START_BUILD,
      CMD_FILL,
      CMD_SORT_LOAD,
      CMD_SORT_RD,
      CMD_SORT_CMP,
      CMD_SORT_STORE,
      CMD_CNT_RD,
      CMD_CNT_NEXT,
      CMD_BUILD_END,
      CMD_Q_START,
      CMD_Q_ITH,
      CMD_SRCH_RD,
      CMD_SRCH_CMP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic fill_last;   // last grid cell this cycle
      logic sort_more;   // a+1 < n
      logic b_last;      // b is the last entry
      logic cnt_go;      // i < n
      logic cnt_hit;     // read distance within limit
      logic srch_go;     // i < size and i < limit
      logic srch_hit;    // read entry matches query
   } status_type;

endpackage

// ===== rtl/core/dsot_ctrl.sv =====
// Controller state machine for the offset table: sequences build and query.
// Depends on dsot_pkg for command and status types.
module dsot_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dsot_pkg::status_type st,
   output dsot_pkg::cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE       = 12'b000000000001,
      S_FILL       = 12'b000000000010,
      S_SORT_CHK   = 12'b000000000100,
      S_SORT_LOAD  = 12'b000000001000,
      S_SORT_RD    = 12'b000000010000,
      S_SORT_CMP   = 12'b000000100000,
      S_SORT_STORE = 12'b000001000000,
      S_CNT_RD     = 12'b000010000000,
      S_CNT_CMP    = 12'b000100000000,
      S_Q_ITH      = 12'b001000000000,
      S_SRCH       = 12'b010000000000,
      S_RESP       = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      srch_cmp_ff, srch_cmp_in;  // search: compare phase

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // next state and command
   always_comb begin
      state_in    = state_ff;
      srch_cmp_in = srch_cmp_ff;
      cmd.op      = dsot_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == dsot_pkg::ACT_BUILD) begin
                  cmd.op   = dsot_pkg::CMD_START_BUILD;
                  state_in = S_FILL;
               end else begin
                  cmd.op   = dsot_pkg::CMD_Q_START;
                  state_in = S_Q_ITH;
               end
            end
         end
         S_FILL: begin
            cmd.op = dsot_pkg::CMD_FILL;
            if (st.fill_last) state_in = S_SORT_CHK;
         end
         S_SORT_CHK: begin
            state_in = st.sort_more ? S_SORT_LOAD : S_CNT_RD;
         end
         S_SORT_LOAD: begin
            cmd.op   = dsot_pkg::CMD_SORT_LOAD;
            state_in = S_SORT_RD;
         end
         S_SORT_RD: begin
            cmd.op   = dsot_pkg::CMD_SORT_RD;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            cmd.op = dsot_pkg::CMD_SORT_CMP;
            if (st.b_last) state_in = S_SORT_STORE;
         end
         S_SORT_STORE: begin
            cmd.op   = dsot_pkg::CMD_SORT_STORE;
            state_in = S_SORT_CHK;
         end
         S_CNT_RD: begin
            if (st.cnt_go) begin
               cmd.op   = dsot_pkg::CMD_CNT_RD;
               state_in = S_CNT_CMP;
            end else begin
               cmd.op   = dsot_pkg::CMD_BUILD_END;
               state_in = S_RESP;
            end
         end
         S_CNT_CMP: begin
            if (st.cnt_hit) begin
               cmd.op   = dsot_pkg::CMD_CNT_NEXT;
               state_in = S_CNT_RD;
            end else begin
               cmd.op   = dsot_pkg::CMD_BUILD_END;
               state_in = S_RESP;
            end
         end
         S_Q_ITH: begin
            cmd.op      = dsot_pkg::CMD_Q_ITH;
            srch_cmp_in = 1'b0;
            state_in    = S_SRCH;
         end
         S_SRCH: begin
            if (!srch_cmp_ff) begin
               if (st.srch_go) begin
                  cmd.op      = dsot_pkg::CMD_SRCH_RD;
                  srch_cmp_in = 1'b1;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               cmd.op      = dsot_pkg::CMD_SRCH_CMP;
               srch_cmp_in = 1'b0;
               if (st.srch_hit) state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         srch_cmp_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         srch_cmp_ff <= srch_cmp_in;
      end
   end

endmodule

// ===== rtl/core/dsot_datapath.sv =====
// Datapath for the offset table: config registers, table memory, counters,
// exchange-sort holding register and result registers. Depends on dsot_pkg.
module dsot_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dsot_pkg::cmd_type                       cmd,
   output dsot_pkg::status_type                    st,
   input  logic                                    csr_valid,
   input  logic [dsot_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [dsot_pkg::CSR_DATA_W-1:0]         csr_data,
   input  logic [dsot_pkg::ADDR_W-1:0]             req_index,
   input  logic signed [dsot_pkg::COORD_W-1:0]     req_rel_x,
   input  logic signed [dsot_pkg::COORD_W-1:0]     req_rel_y,
   input  logic [dsot_pkg::CNT_W-1:0]              req_search_limit,
   output logic [7:0]                              rsp_entry_count,
   output logic [7:0]                              rsp_count_in_range,
   output logic                                    rsp_ith_valid,
   output logic signed [dsot_pkg::COORD_W-1:0]     rsp_ith_x,
   output logic signed [dsot_pkg::COORD_W-1:0]     rsp_ith_y,
   output logic                                    rsp_found,
   output logic [7:0]                              rsp_found_index
);

   localparam int AW = dsot_pkg::ADDR_W;
   localparam int CW = dsot_pkg::CNT_W;
   localparam int XW = dsot_pkg::COORD_W;

   // config registers
   logic [2:0]                     max_dx_ff, max_dy_ff;
   logic                           allow_zero_ff;
   logic [dsot_pkg::DIST_W-1:0]    limit_ff;

   // table memory
   dsot_pkg::entry_type mem [dsot_pkg::TABLE_DEPTH];
   dsot_pkg::entry_type rd_ff, cur_ff, cur_in, wr_data;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;

   // build and scan counters
   logic signed [XW-1:0] fx_ff, fy_ff, hx_ff, hy_ff;
   logic [CW-1:0]        n_ff, a_ff, b_ff, i_ff;
   logic [7:0]           size_ff, inrange_ff;

   // query latches
   logic signed [XW-1:0] qx_ff, qy_ff;
   logic [CW-1:0]        qlim_ff;
   logic [AW-1:0]        qidx_ff;

   // result registers
   logic                 ith_valid_ff, found_ff;
   logic signed [XW-1:0] ith_x_ff, ith_y_ff;
   logic [7:0]           fidx_ff;

   // clamped half-extents
   logic [2:0]           hx_sat, hy_sat;
   assign hx_sat = (32'(max_dx_ff) > dsot_pkg::MAX_HALF_EXTENT) ?
                   3'(dsot_pkg::MAX_HALF_EXTENT) : max_dx_ff;
   assign hy_sat = (32'(max_dy_ff) > dsot_pkg::MAX_HALF_EXTENT) ?
                   3'(dsot_pkg::MAX_HALF_EXTENT) : max_dy_ff;

   // squared distance of the current grid cell
   logic signed [7:0] sqx, sqy;
   logic [7:0]        dsum;
   logic              fill_take;
   assign sqx  = 8'(fx_ff) * 8'(fx_ff);
   assign sqy  = 8'(fy_ff) * 8'(fy_ff);
   assign dsum = 8'(sqx) + 8'(sqy);
   assign fill_take = ((fx_ff != '0) || (fy_ff != '0) || allow_zero_ff) &&
                      (32'(n_ff) < dsot_pkg::TABLE_DEPTH);

   // status to the controller
   always_comb begin
      st.fill_last = (fx_ff == hx_ff) && (fy_ff == hy_ff);
      st.sort_more = (a_ff + CW'(1)) < n_ff;
      st.b_last    = (b_ff + CW'(1)) >= n_ff;
      st.cnt_go    = i_ff < n_ff;
      st.cnt_hit   = rd_ff.d <= limit_ff;
      st.srch_go   = (i_ff < CW'(size_ff)) && (i_ff < qlim_ff);
      st.srch_hit  = (rd_ff.x == qx_ff) && (rd_ff.y == qy_ff);
   end

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = n_ff[AW-1:0];
      wr_data = cur_ff;
      rd_en   = 1'b0;
      rd_addr = i_ff[AW-1:0];
      cur_in  = cur_ff;
      unique case (cmd.op)
         dsot_pkg::CMD_FILL: begin
            wr_en   = fill_take;
            wr_data = '{x: fx_ff, y: fy_ff, d: dsum[dsot_pkg::DIST_W-1:0]};
         end
         dsot_pkg::CMD_SORT_LOAD: begin
            rd_en   = 1'b1;
            rd_addr = a_ff[AW-1:0];
         end
         dsot_pkg::CMD_SORT_RD: begin
            cur_in  = rd_ff;
            rd_en   = 1'b1;
            rd_addr = b_ff[AW-1:0];
         end
         dsot_pkg::CMD_SORT_CMP: begin
            // next b read overlaps with the swap write at b
            rd_en   = 1'b1;
            rd_addr = b_ff[AW-1:0] + AW'(1);
            if (rd_ff.d < cur_ff.d) begin
               wr_en   = 1'b1;
               wr_addr = b_ff[AW-1:0];
               wr_data = cur_ff;
               cur_in  = rd_ff;
            end
         end
         dsot_pkg::CMD_SORT_STORE: begin
            wr_en   = 1'b1;
            wr_addr = a_ff[AW-1:0];
         end
         dsot_pkg::CMD_CNT_RD, dsot_pkg::CMD_SRCH_RD: begin
            rd_en = 1'b1;
         end
         dsot_pkg::CMD_Q_START: begin
            rd_en   = 1'b1;
            rd_addr = req_index;
         end
         default: ;
      endcase
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // config write
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dx_ff     <= 3'd1;
         max_dy_ff     <= 3'd1;
         allow_zero_ff <= 1'b0;
         limit_ff      <= 7'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            dsot_pkg::CSR_MAX_DX:     max_dx_ff     <= csr_data[2:0];
            dsot_pkg::CSR_MAX_DY:     max_dy_ff     <= csr_data[2:0];
            dsot_pkg::CSR_ALLOW_ZERO: allow_zero_ff <= csr_data[0];
            dsot_pkg::CSR_DIST_LIMIT: limit_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // table size and in-range count
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= '0;
         inrange_ff <= '0;
      end else if (cmd.op == dsot_pkg::CMD_BUILD_END) begin
         size_ff    <= n_ff[7:0];
         inrange_ff <= i_ff[7:0];
      end
   end

   // counters, holding register and results
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      unique case (cmd.op)
         dsot_pkg::CMD_START_BUILD: begin
            hx_ff        <= XW'(hx_sat);
            hy_ff        <= XW'(hy_sat);
            fx_ff        <= -XW'(hx_sat);
            fy_ff        <= -XW'(hy_sat);
            n_ff         <= '0;
            a_ff         <= '0;
            i_ff         <= '0;
            ith_valid_ff <= 1'b0;
            ith_x_ff     <= '0;
            ith_y_ff     <= '0;
            found_ff     <= 1'b0;
            fidx_ff      <= '0;
         end
         dsot_pkg::CMD_FILL: begin
            if (fill_take) n_ff <= n_ff + CW'(1);
            if (fy_ff == hy_ff) begin
               fy_ff <= -hy_ff;
               fx_ff <= fx_ff + XW'(1);
            end else begin
               fy_ff <= fy_ff + XW'(1);
            end
         end
         dsot_pkg::CMD_SORT_LOAD:  b_ff <= a_ff + CW'(1);
         dsot_pkg::CMD_SORT_CMP:   b_ff <= b_ff + CW'(1);
         dsot_pkg::CMD_SORT_STORE: a_ff <= a_ff + CW'(1);
         // in-range count advances only on a hit
         dsot_pkg::CMD_CNT_NEXT:   i_ff <= i_ff + CW'(1);
         dsot_pkg::CMD_Q_START: begin
            qx_ff    <= req_rel_x;
            qy_ff    <= req_rel_y;
            qlim_ff  <= req_search_limit;
            qidx_ff  <= req_index;
            i_ff     <= '0;
            found_ff <= 1'b0;
            fidx_ff  <= '0;
         end
         dsot_pkg::CMD_Q_ITH: begin
            ith_valid_ff <= qidx_ff < size_ff;
            ith_x_ff     <= (qidx_ff < size_ff) ? rd_ff.x : '0;
            ith_y_ff     <= (qidx_ff < size_ff) ? rd_ff.y : '0;
         end
         dsot_pkg::CMD_SRCH_RD: ;
         dsot_pkg::CMD_SRCH_CMP: begin
            if (st.srch_hit) begin
               found_ff <= 1'b1;
               fidx_ff  <= i_ff[7:0];
            end else begin
               i_ff <= i_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_entry_count    = size_ff;
   assign rsp_count_in_range = inrange_ff;
   assign rsp_ith_valid      = ith_valid_ff;
   assign rsp_ith_x          = ith_x_ff;
   assign rsp_ith_y          = ith_y_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_index    = fidx_ff;

endmodule

// ===== rtl/core/distance_sorted_offset_table_unit.sv =====
// Top level of the distance-sorted offset table.
// Depends on dsot_pkg, dsot_ctrl and dsot_datapath.
//
// Usage:
//  - csr_ channel writes a register (0 max_dx, 1 max_dy, 2 allow_zero,
//    3 dist_sq_limit); always ready, other indexes ignored. Write only idle.
//  - req_ channel takes one item: action 0 rebuilds the table from the
//    registers, action 1 reads entry index and searches for (rel_x, rel_y)
//    among the first search_limit entries.
//  - rsp_ channel returns one result per item, held until rsp_ready.
// Build: fill the grid one cell a cycle; then exchange sort on the table
// memory (per outer step: check, load, read, then one compare a cycle with
// the table's read and write ports used together, then store); then an
// in-range scan (read then compare per entry) up to the first entry out of range.
// A query reads the entry at index, then searches entry by entry (memory
// read then compare), stopping at the first match.
// One item is in flight at a time; req_ready is low from acceptance until
// the result is transferred.
// Reset: registers to defaults, table empty (entry_count 0); no memory
// clearing pass. A stalled rsp_ready holds the result and blocks new items.
module distance_sorted_offset_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dsot_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsot_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [7:0]                          req_index,
   input  logic signed [3:0]                   req_rel_x,
   input  logic signed [3:0]                   req_rel_y,
   input  logic [8:0]                          req_search_limit,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_entry_count,
   output logic [7:0]                          rsp_count_in_range,
   output logic                                rsp_ith_valid,
   output logic signed [3:0]                   rsp_ith_x,
   output logic signed [3:0]                   rsp_ith_y,
   output logic                                rsp_found,
   output logic [7:0]                          rsp_found_index
);

   dsot_pkg::cmd_type    cmd;
   dsot_pkg::status_type st;

   assign csr_ready = 1'b1;

   // controller
   dsot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .st         (st),
      .cmd        (cmd)
   );

   // datapath
   dsot_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_index          (req_index),
      .req_rel_x          (req_rel_x),
      .req_rel_y          (req_rel_y),
      .req_search_limit   (req_search_limit),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_count_in_range (rsp_count_in_range),
      .rsp_ith_valid      (rsp_ith_valid),
      .rsp_ith_x          (rsp_ith_x),
      .rsp_ith_y          (rsp_ith_y),
      .rsp_found          (rsp_found),
      .rsp_found_index    (rsp_found_index)
   );

`ifndef SYNTHESIS
   a_ith_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ith_valid |-> rsp_ith_x == '0 && rsp_ith_y == '0)
      else $error("ith offset not zero when invalid");
   a_found_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_found_index < rsp_entry_count)
      else $error("found index beyond table");
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_index == '0)
      else $error("found index set without hit");
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_in_range <= rsp_entry_count)
      else $error("in-range count exceeds entry count");
`endif

endmodule
